### hdl/frapq_pkg.sv
// ----------------------------------------------------------------------------
// frapq_pkg: shared constants for the range-add / point-query tree core
// Widths of the tree store, the position arithmetic and the data path.
// ----------------------------------------------------------------------------
package frapq_pkg;

  // Number of entries in the tree store.
  localparam int TREE_DEPTH = 1024;
  // Address width of the tree store.
  localparam int IDX_W = $clog2(TREE_DEPTH);
  // Width of the position and active size fields at the ports.
  localparam int FIELD_W = 11;
  // Internal position width: wide enough for a field plus one, and for a climb
  // that may step up to twice the store depth.
  localparam int POS_W = (IDX_W + 2 > FIELD_W + 1) ? IDX_W + 2 : FIELD_W + 1;
  // Data width of tree entries and results.
  localparam int DATA_W = 64;
  // Active size after reset.
  localparam logic [FIELD_W-1:0] ACTIVE_SIZE_RESET = FIELD_W'(1024);

endpackage

### hdl/fenwick_range_add_point_query_core.sv
// A range add visits the tree levels of each of its two climbs with a read and a write
// per level. A point query reads and accumulates one entry per level inside the store,
// skips the levels past it, and may stall on the output. One item is handled at a time;
// the next is taken only in the idle state, after the previous one ends. After rst the
// store is cleared, during which no item is taken; configuration writes are.
// ----------------------------------------------------------------------------
// fenwick_range_add_point_query_core
// Binary indexed tree over a difference array. Mode 0 adds delta over a
// range of positions, mode 1 returns the current value at one position.
// ----------------------------------------------------------------------------
module fenwick_range_add_point_query_core (
  input  logic                                   clk,
  input  logic                                   rst,
  // Configuration.
  input  logic                                   cfg_wr_en,
  input  logic [frapq_pkg::FIELD_W-1:0]          cfg_wr_data,
  // Input channel.
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   mode,
  input  logic [frapq_pkg::FIELD_W-1:0]          first_pos,
  input  logic [frapq_pkg::FIELD_W-1:0]          last_pos,
  input  logic signed [frapq_pkg::DATA_W-1:0]    delta,
  // Output channel.
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [frapq_pkg::DATA_W-1:0]    element_value
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_QRY_RD,
    ST_QRY_ACC,
    ST_QRY_DONE
  } state_t;

  state_t                          state;
  logic [frapq_pkg::FIELD_W-1:0]   active_size;
  logic [frapq_pkg::IDX_W-1:0]     clr_idx;
  logic [frapq_pkg::POS_W-1:0]     pos;
  logic [frapq_pkg::POS_W-1:0]     last_plus;
  logic                            neg;
  logic [frapq_pkg::DATA_W-1:0]    delta_r;
  logic [frapq_pkg::DATA_W-1:0]    acc;

  // Tree store and its port.
  logic [frapq_pkg::DATA_W-1:0]    mem [frapq_pkg::TREE_DEPTH];
  logic                            mem_we;
  logic [frapq_pkg::IDX_W-1:0]     mem_addr;
  logic [frapq_pkg::DATA_W-1:0]    mem_wdata;
  logic [frapq_pkg::DATA_W-1:0]    mem_rdata;

  // Position helpers.
  logic [frapq_pkg::POS_W-1:0]     bound;
  logic [frapq_pkg::POS_W-1:0]     pos_low;
  logic [frapq_pkg::POS_W-1:0]     pos_dec;
  logic [frapq_pkg::POS_W-1:0]     pos_m1;
  logic                            upd_ok;
  logic                            qry_in_store;

  // Shared adder.
  logic [frapq_pkg::DATA_W-1:0]    add_b;
  logic                            add_inv;
  logic [frapq_pkg::DATA_W-1:0]    add_sum;

  // Updates are bounded by the smaller of the active size and the store depth.
  always_comb begin
    if (frapq_pkg::POS_W'(active_size) > frapq_pkg::POS_W'(frapq_pkg::TREE_DEPTH)) begin
      bound = frapq_pkg::POS_W'(frapq_pkg::TREE_DEPTH);
    end else begin
      bound = frapq_pkg::POS_W'(active_size);
    end
  end

  // Lowest set bit, the climb step, and the descent step.
  assign pos_m1       = pos - frapq_pkg::POS_W'(1);
  assign pos_low      = pos & ~pos_m1;
  assign pos_dec      = pos & pos_m1;
  assign upd_ok       = (pos != '0) && (pos <= bound);
  assign qry_in_store = (pos <= frapq_pkg::POS_W'(frapq_pkg::TREE_DEPTH));

  // One 64-bit adder serves both the update and the query accumulation.
  // The second climb of a range add subtracts delta by inverting with a carry in.
  assign add_b   = (state == ST_QRY_ACC) ? acc : delta_r;
  assign add_inv = (state == ST_ADD_WR) && neg;
  assign add_sum = mem_rdata + (add_b ^ {frapq_pkg::DATA_W{add_inv}})
                   + frapq_pkg::DATA_W'(add_inv);

  // Store port control.
  assign mem_we    = (state == ST_CLEAR) || (state == ST_ADD_WR);
  assign mem_addr  = (state == ST_CLEAR) ? clr_idx : pos_m1[frapq_pkg::IDX_W-1:0];
  assign mem_wdata = (state == ST_CLEAR) ? '0 : add_sum;

  // Single-port tree store with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_addr];
  end

  assign in_ready = (state == ST_IDLE);

  // Sequencer, configuration register and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_idx     <= '0;
      out_valid   <= 1'b0;
      active_size <= frapq_pkg::ACTIVE_SIZE_RESET;
    end else begin
      if (cfg_wr_en) begin
        active_size <= cfg_wr_data;
      end

      // The result leaves on an output transfer, unless a new one is loaded below.
      if (out_valid && out_ready && (state != ST_QRY_DONE)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        // Zero the store one entry per cycle.
        ST_CLEAR: begin
          clr_idx <= clr_idx + frapq_pkg::IDX_W'(1);
          if (clr_idx == frapq_pkg::IDX_W'(frapq_pkg::TREE_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end

        // Take a new item.
        ST_IDLE: begin
          if (in_valid) begin
            pos       <= frapq_pkg::POS_W'(first_pos);
            last_plus <= frapq_pkg::POS_W'(last_pos) + frapq_pkg::POS_W'(1);
            delta_r   <= $unsigned(delta);
            neg       <= 1'b0;
            acc       <= '0;
            state     <= mode ? ST_QRY_RD : ST_ADD_RD;
          end
        end

        // Read the next entry on the climb, or move to the second climb.
        ST_ADD_RD: begin
          if (upd_ok) begin
            state <= ST_ADD_WR;
          end else if (!neg) begin
            neg <= 1'b1;
            pos <= last_plus;
          end else begin
            state <= ST_IDLE;
          end
        end

        // Write back the updated entry and climb by the lowest set bit.
        ST_ADD_WR: begin
          pos   <= pos + pos_low;
          state <= ST_ADD_RD;
        end

        // Read the next entry on the descent; entries beyond the store count as zero.
        ST_QRY_RD: begin
          if (pos == '0) begin
            state <= ST_QRY_DONE;
          end else if (!qry_in_store) begin
            pos <= pos_dec;
          end else begin
            state <= ST_QRY_ACC;
          end
        end

        // Accumulate the entry and clear the lowest set bit.
        ST_QRY_ACC: begin
          acc   <= add_sum;
          pos   <= pos_dec;
          state <= ST_QRY_RD;
        end

        // Hand the sum to the output register once it is free.
        ST_QRY_DONE: begin
          if (!out_valid || out_ready) begin
            element_value <= $signed(acc);
            out_valid     <= 1'b1;
            state         <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### hdl/frapq_checker.sv
// ----------------------------------------------------------------------------
// frapq_checker: port-level checks for the range-add / point-query core
// Watches the handshakes and the reset behavior seen at the top level ports.
// ----------------------------------------------------------------------------
module frapq_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                mode,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [frapq_pkg::DATA_W-1:0] element_value
);

  // After reset the store is being cleared, so no input transfer and no result.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> (!in_ready && !out_valid))
    else $error("core ready or showing a result right after reset");

  // No item completes in the idle state, so ready drops after an input transfer.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("core ready in the cycle after an input transfer");

  // A range add produces no result right after it is taken.
  a_add_no_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !mode) |=> !$rose(out_valid))
    else $error("result appeared right after a range add");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(element_value)))
    else $error("stalled result dropped or changed");

endmodule

bind fenwick_range_add_point_query_core frapq_checker u_frapq_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .mode          (mode),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .element_value (element_value)
);
